### hdl/tepq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the timed event priority queue.
// No dependencies; used by the cell and the top level.
package tepq_pkg;

  localparam int DefaultDepth = 64;

  localparam int TimeW = 32;
  localparam int KindW = 1;
  localparam int UnitW = 3;
  localparam int TagW  = 8;
  localparam int OccW  = 7;

  // operation codes on the request channel
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [TimeW-1:0] time_key;
    logic [KindW-1:0] kind;
    logic [UnitW-1:0] unit;
    logic [TagW-1:0]  tag;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t item;
  } cell_ctl_t;

endpackage

### hdl/tepq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response sides.
// No dependencies.
interface tepq_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] event_time;
  logic        event_kind;
  logic [2:0]  unit_id;
  logic [7:0]  request_tag;

  modport source (output valid, op, event_time, event_kind, unit_id, request_tag,
                  input ready);
  modport sink   (input valid, op, event_time, event_kind, unit_id, request_tag,
                  output ready);
endinterface

interface tepq_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        popped_valid;
  logic [31:0] popped_time;
  logic        popped_kind;
  logic [2:0]  popped_unit;
  logic [7:0]  popped_tag;
  logic [6:0]  occupancy;

  modport source (output valid, status, popped_valid, popped_time, popped_kind,
                  popped_unit, popped_tag, occupancy, input ready);
  modport sink   (input valid, status, popped_valid, popped_time, popped_kind,
                  popped_unit, popped_tag, occupancy, output ready);
endinterface

### hdl/tepq_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted shift-register queue.
// Depends on tepq_pkg.
module tepq_cell (
  input  logic              clk,
  input  tepq_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  tepq_pkg::entry_t  left_entry,
  input  logic              left_ge,
  input  tepq_pkg::entry_t  right_entry,
  output tepq_pkg::entry_t  entry,
  output logic              ge
);
  import tepq_pkg::*;

  entry_t entry_next;

  // slot is free or holds a time not below the incoming one
  assign ge = !occupied || (entry.time_key >= ctl.item.time_key);

  // insert shifts right from the insertion point, pop shifts left
  always_comb begin
    entry_next = entry;
    if (ctl.ins) begin
      if (ge) begin
        entry_next = left_ge ? left_entry : ctl.item;
      end
    end else if (ctl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### hdl/timed_event_priority_queue.sv
`timescale 1ns / 1ps
// Timed event priority queue: up to QUEUE_DEPTH events kept sorted by time in a
// row of cells, earliest at the front. Every request (insert or pop) gets one
// response; one request is taken per clock cycle while the response register
// can be refilled, since every cell compares its own time with the incoming
// one in parallel and shifts in the same cycle. The response is registered and
// appears in the cycle after the request is taken. Among equal times the most
// recent insert pops first. Pop on empty returns status 1, insert into a full
// queue is dropped with status 2. Depends on tepq_pkg and tepq_if.
module timed_event_priority_queue #(
  parameter int QUEUE_DEPTH = tepq_pkg::DefaultDepth
) (
  input  logic       clk,
  input  logic       rst,
  tepq_req_if.sink   req,
  tepq_rsp_if.source rsp
);
  import tepq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  logic            accept;
  logic            full;
  logic            empty;
  cell_ctl_t       ctl;
  entry_t          cells [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] occupied;
  status_t         status_next;

  // handshake: take a request whenever the response register can be refilled
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CntW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  // command broadcast to the cells
  always_comb begin
    ctl.ins           = accept && (req.op == OP_INSERT) && !full;
    ctl.pop           = accept && (req.op == OP_POP) && !empty;
    ctl.item.time_key = req.event_time;
    ctl.item.kind     = req.event_kind;
    ctl.item.unit     = req.unit_id;
    ctl.item.tag      = req.request_tag;
  end

  // row of cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (count > CntW'(i));
    if (i == 0) begin : g_head
      tepq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .left_entry (ctl.item),
        .left_ge    (1'b0),
        .right_entry(cells[i+1]),
        .entry      (cells[i]),
        .ge         (ge[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_tail
      tepq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .left_entry (cells[i-1]),
        .left_ge    (ge[i-1]),
        .right_entry(ctl.item),
        .entry      (cells[i]),
        .ge         (ge[i])
      );
    end else begin : g_mid
      tepq_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .occupied   (occupied[i]),
        .left_entry (cells[i-1]),
        .left_ge    (ge[i-1]),
        .right_entry(cells[i+1]),
        .entry      (cells[i]),
        .ge         (ge[i])
      );
    end
  end

  // occupancy and status
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (ctl.ins) begin
      count_next = count + CntW'(1);
    end else if (ctl.pop) begin
      count_next = count - CntW'(1);
    end
    if (accept && (req.op == OP_INSERT) && full) begin
      status_next = ST_FULL;
    end else if (accept && (req.op == OP_POP) && empty) begin
      status_next = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status       <= status_next;
      rsp.popped_valid <= ctl.pop;
      rsp.popped_time  <= ctl.pop ? cells[0].time_key : '0;
      rsp.popped_kind  <= ctl.pop ? cells[0].kind : '0;
      rsp.popped_unit  <= ctl.pop ? cells[0].unit : '0;
      rsp.popped_tag   <= ctl.pop ? cells[0].tag : '0;
      rsp.occupancy    <= OccW'(count_next);
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> (count == $past(count) - CntW'(1)))
    else $error("pop did not remove one entry");

  a_ins_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (count == $past(count) + CntW'(1)))
    else $error("insert did not add one entry");

  a_popped_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.popped_valid) |-> (rsp.status == ST_OK))
    else $error("popped entry with error status");

  a_front_min: assert property (@(posedge clk) disable iff (rst)
    (count > CntW'(1)) |-> (cells[0].time_key <= cells[1].time_key))
    else $error("front entry not earliest");

endmodule
